// ----- rtl/rcb_pkg.sv -----
// Shared types and constants for the rectangle clip-to-box-list block.
`default_nettype none

package rcb_pkg;

  localparam int unsigned MAX_BOXES   = 16;
  localparam int unsigned EDGE_W      = 13;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned FAR_W       = 18;
  localparam int unsigned CODE_W      = 15;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_FILL   = 2'd2
  } act_e;

  typedef struct packed {
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    act_e                       kind;
    box_t                       box;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [FAR_W-1:0]    xx;
    logic signed [FAR_W-1:0]    yy;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } qout_t;

endpackage

`default_nettype wire

// ----- rtl/rcb_front.sv -----
// Front end: takes requests, translates fill rectangles by the origin and queues them.
`default_nettype none

module rcb_front import rcb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      full_i,
  input  logic [1:0]                action_i,
  input  logic [EDGE_W-1:0]         box_left_i,
  input  logic [EDGE_W-1:0]         box_top_i,
  input  logic [EDGE_W-1:0]         box_right_i,
  input  logic [EDGE_W-1:0]         box_bottom_i,
  input  logic signed [COORD_W-1:0] rect_x_i,
  input  logic signed [COORD_W-1:0] rect_y_i,
  input  logic [COORD_W-1:0]        rect_width_i,
  input  logic [COORD_W-1:0]        rect_height_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [COORD_W-1:0] origin_x_q, origin_x_d;
  logic [COORD_W-1:0] origin_y_q, origin_y_d;
  logic [COORD_W-1:0] x_wrap, y_wrap;
  logic               known;

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_d = cfg_wdata_i;
        CFG_ORIGIN_Y: origin_y_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
    end
  end

  always_comb begin
    known = 1'b0;
    case (action_i)
      ACT_CLEAR, ACT_APPEND, ACT_FILL: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // The near corner wraps to 16 bits; the far edges keep two extra bits.
  assign x_wrap = rect_x_i + origin_x_q;
  assign y_wrap = rect_y_i + origin_y_q;

  always_comb begin
    cmd_o.kind       = act_e'(action_i);
    cmd_o.box.left   = box_left_i;
    cmd_o.box.top    = box_top_i;
    cmd_o.box.right  = box_right_i;
    cmd_o.box.bottom = box_bottom_i;
    cmd_o.x          = x_wrap;
    cmd_o.y          = y_wrap;
    cmd_o.xx         = $signed({{(FAR_W-COORD_W){x_wrap[COORD_W-1]}}, x_wrap})
                     + $signed({{(FAR_W-COORD_W){1'b0}}, rect_width_i});
    cmd_o.yy         = $signed({{(FAR_W-COORD_W){y_wrap[COORD_W-1]}}, y_wrap})
                     + $signed({{(FAR_W-COORD_W){1'b0}}, rect_height_i});
  end

  assign push_o = start_i && !full_i && known;

endmodule

`default_nettype wire

// ----- rtl/rcb_queue.sv -----
// Short command queue between the front end and the clipping back end.
`default_nettype none

module rcb_queue import rcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output logic  full_o,
  output qout_t out_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  assign full_o    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign out_o.vld = (cnt_q != '0);
  assign out_o.cmd = mem_q[rptr_q];

endmodule

`default_nettype wire

// ----- rtl/rcb_back.sv -----
// Back end: holds the box table, scans it for each fill and emits clipped line requests.
`default_nettype none

module rcb_back import rcb_pkg::*; #(
  parameter int unsigned MaxBoxes = MAX_BOXES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qout_t             q_i,
  output logic              pop_o,
  output logic              valid_o,
  output logic [WORD_W-1:0] start_word_o,
  output logic [WORD_W-1:0] end_word_o,
  output logic [CODE_W-1:0] width_code_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CntW = $clog2(MaxBoxes + 1);
  localparam int unsigned PsyW = EDGE_W + 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         cnt_q;
  logic [IdxW-1:0]         idx_q;
  logic signed [FAR_W-1:0] x_q, y_q, xx_q, yy_q;

  box_t                    mem_q [MaxBoxes];
  box_t                    rd_q;
  logic                    s1_vld_q, s1_last_q;
  logic                    s2_vld_q, s2_last_q, s2_ne_q;
  logic [EDGE_W-1:0]       s2_cx_q, s2_cy_q, s2_cxx_q, s2_cyy_q;
  logic                    flush_q;

  logic                    pend_vld_q;
  logic [WORD_W-1:0]       pend_start_q, pend_end_q;
  logic [CODE_W-1:0]       pend_lw_q;

  logic                    valid_q, last_q;
  logic [WORD_W-1:0]       start_q, end_q;
  logic [CODE_W-1:0]       lw_q;

  logic                    wr_en, table_full, last_issue;
  logic [CntW-1:0]         idx_next;
  logic signed [FAR_W-1:0] b_left, b_top, b_right, b_bottom;
  logic signed [FAR_W-1:0] cx, cy, cxx, cyy;
  logic [EDGE_W-1:0]       height;
  logic [CODE_W-1:0]       new_lw;
  logic [PsyW-1:0]         new_psy;
  logic [WORD_W-1:0]       new_start, new_end;

  assign pop_o      = (state_q == ST_IDLE) && q_i.vld;
  assign table_full = (cnt_q == CntW'(MaxBoxes));
  assign wr_en      = pop_o && (q_i.cmd.kind == ACT_APPEND) && !table_full;
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign last_issue = (idx_next == cnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IdxW-1:0]] <= q_i.cmd.box;
    end
    rd_q <= mem_q[idx_q];
  end

  always_comb begin
    b_left   = $signed({{(FAR_W-EDGE_W){1'b0}}, rd_q.left});
    b_top    = $signed({{(FAR_W-EDGE_W){1'b0}}, rd_q.top});
    b_right  = $signed({{(FAR_W-EDGE_W){1'b0}}, rd_q.right});
    b_bottom = $signed({{(FAR_W-EDGE_W){1'b0}}, rd_q.bottom});
    cx       = (x_q > b_left) ? x_q : b_left;
    cy       = (y_q > b_top) ? y_q : b_top;
    cxx      = (xx_q < b_right) ? xx_q : b_right;
    cyy      = (yy_q < b_bottom) ? yy_q : b_bottom;
  end

  // A non-empty intersection always lies inside the 13-bit edge range.
  always_comb begin
    height    = s2_cyy_q - s2_cy_q;
    new_lw    = {height, 2'b00} - CODE_W'(1);
    new_psy   = PsyW'({s2_cy_q, 3'b000}) + PsyW'(new_lw);
    new_start = {s2_cx_q, {(WORD_W-EDGE_W-PsyW){1'b0}}, new_psy};
    new_end   = {s2_cxx_q, {(WORD_W-EDGE_W-PsyW){1'b0}}, new_psy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      idx_q        <= '0;
      x_q          <= '0;
      y_q          <= '0;
      xx_q         <= '0;
      yy_q         <= '0;
      s1_vld_q     <= 1'b0;
      s1_last_q    <= 1'b0;
      s2_vld_q     <= 1'b0;
      s2_last_q    <= 1'b0;
      s2_ne_q      <= 1'b0;
      s2_cx_q      <= '0;
      s2_cy_q      <= '0;
      s2_cxx_q     <= '0;
      s2_cyy_q     <= '0;
      flush_q      <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_start_q <= '0;
      pend_end_q   <= '0;
      pend_lw_q    <= '0;
      valid_q      <= 1'b0;
      last_q       <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      lw_q         <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (q_i.cmd.kind)
              ACT_CLEAR: cnt_q <= '0;
              ACT_APPEND: begin
                if (!table_full) begin
                  cnt_q <= cnt_q + CntW'(1);
                end
              end
              ACT_FILL: begin
                x_q  <= FAR_W'(q_i.cmd.x);
                y_q  <= FAR_W'(q_i.cmd.y);
                xx_q <= q_i.cmd.xx;
                yy_q <= q_i.cmd.yy;
                if (cnt_q != '0) begin
                  idx_q   <= '0;
                  state_q <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (last_issue) begin
            state_q <= ST_WAIT;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_WAIT: begin
          if (flush_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      s1_vld_q  <= (state_q == ST_SCAN);
      s1_last_q <= (state_q == ST_SCAN) && last_issue;

      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && s1_last_q;
      s2_ne_q   <= (cx < cxx) && (cy < cyy);
      s2_cx_q   <= cx[EDGE_W-1:0];
      s2_cy_q   <= cy[EDGE_W-1:0];
      s2_cxx_q  <= cxx[EDGE_W-1:0];
      s2_cyy_q  <= cyy[EDGE_W-1:0];

      flush_q   <= s2_vld_q && s2_last_q;

      // A result is held back until the one after it is known, so that the final one can be flagged.
      valid_q <= 1'b0;
      if (s2_vld_q && s2_ne_q) begin
        if (pend_vld_q) begin
          valid_q <= 1'b1;
          last_q  <= 1'b0;
          start_q <= pend_start_q;
          end_q   <= pend_end_q;
          lw_q    <= pend_lw_q;
        end
        pend_vld_q   <= 1'b1;
        pend_start_q <= new_start;
        pend_end_q   <= new_end;
        pend_lw_q    <= new_lw;
      end else if (flush_q && pend_vld_q) begin
        valid_q    <= 1'b1;
        last_q     <= 1'b1;
        start_q    <= pend_start_q;
        end_q      <= pend_end_q;
        lw_q       <= pend_lw_q;
        pend_vld_q <= 1'b0;
      end
    end
  end

  assign valid_o      = valid_q;
  assign last_o       = last_q;
  assign start_word_o = start_q;
  assign end_word_o   = end_q;
  assign width_code_o = lw_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBoxes))
    else $error("Box count exceeds the table size.");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("Request emitted right after the final one of a fill.");

  a_flush_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !s1_vld_q && !s2_vld_q && (state_q == ST_WAIT))
    else $error("Scan pipeline still busy at the end of a fill.");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q && !s1_vld_q && !s2_vld_q)
    else $error("Back end idle with work in flight.");

endmodule

`default_nettype wire

// ----- rtl/rect_clip_to_box_list.sv -----
// Top level of the rectangle clip-to-box-list block.
`default_nettype none

// Requests arrive on start_i with action_i and the box or rectangle fields; a
// request is taken at a clock edge where start_i is high and busy_o is low,
// and one with the unused action code is ignored. Clear and append requests
// load a table of up to MaxBoxes clip boxes. A fill request carries a
// rectangle, which is moved by the origin registers and then clipped against
// every stored box in table order. Each non-empty overlap gives one result on
// valid_o for a single cycle, with last_o on the final one. Requests go
// through a two-entry queue, so busy_o rises only when it is full. The back
// end applies a clear or append as it pops it, and pops no further request
// until a fill is done with the table, which has a single read port and is
// scanned one box per cycle. Each result is held until the next overlap or
// the end of the scan is known. Results cannot be held off. Reset empties
// the table and the queue and sets both origins to zero. The origin registers
// are written through cfg_we_i, cfg_idx_i and cfg_wdata_i, by the user only
// while no request is in flight; the block itself does not enforce this.
module rect_clip_to_box_list import rcb_pkg::*; #(
  parameter int unsigned MaxBoxes = MAX_BOXES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                action_i,
  input  logic [EDGE_W-1:0]         box_left_i,
  input  logic [EDGE_W-1:0]         box_top_i,
  input  logic [EDGE_W-1:0]         box_right_i,
  input  logic [EDGE_W-1:0]         box_bottom_i,
  input  logic signed [COORD_W-1:0] rect_x_i,
  input  logic signed [COORD_W-1:0] rect_y_i,
  input  logic [COORD_W-1:0]        rect_width_i,
  input  logic [COORD_W-1:0]        rect_height_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,
  output logic                      valid_o,
  output logic [WORD_W-1:0]         start_word_o,
  output logic [WORD_W-1:0]         end_word_o,
  output logic [CODE_W-1:0]         width_code_o,
  output logic                      last_o
);

  logic  push, pop, full;
  cmd_t  cmd;
  qout_t q_out;

  rcb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .full_i        (full),
    .action_i      (action_i),
    .box_left_i    (box_left_i),
    .box_top_i     (box_top_i),
    .box_right_i   (box_right_i),
    .box_bottom_i  (box_bottom_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  rcb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .out_o  (q_out)
  );

  rcb_back #(
    .MaxBoxes (MaxBoxes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q_out),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .start_word_o (start_word_o),
    .end_word_o   (end_word_o),
    .width_code_o (width_code_o),
    .last_o       (last_o)
  );

  assign busy_o = full;

endmodule

`default_nettype wire

// ----- sim/tb_rect_clip_to_box_list.sv -----
// Self-checking testbench for rect_clip_to_box_list: predicts clipped fill primitives.
module tb_rect_clip_to_box_list;
  import rcb_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS   = 53;
  localparam int unsigned SHIFT_X       = 19;
  localparam int unsigned SHIFT_Y       = 3;
  localparam int unsigned SHIFT_H       = 2;
  localparam int          EDGE_MAX      = 8191;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] start_word;
    logic [WORD_W-1:0] end_word;
    logic [CODE_W-1:0] width_code;
    logic              last;
  } line_prim_t;

  typedef struct packed {
    logic [1:0]         act;
    box_t               box;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rw;
    logic [COORD_W-1:0] rh;
  } draw_req_t;

  class clip_tracker;
    box_t                      boxes[MAX_BOXES];
    int unsigned               n_boxes;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    line_prim_t                pending[$];
    int unsigned               errors;

    function new();
      n_boxes = 0;
      org_x   = '0;
      org_y   = '0;
      errors  = 0;
    endfunction

    function void set_origin(logic idx, logic [COORD_W-1:0] val);
      if (idx == CFG_ORIGIN_X) begin
        org_x = val;
      end else begin
        org_y = val;
      end
    endfunction

    // Returns 1 for a clear, a fill or an append that fits the table; 0 otherwise.
    function bit note_request(draw_req_t r);
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
      int                        x0, y0, x1, y1, cx0, cy0, cx1, cy1;
      logic [WORD_W-1:0]         lw, psy;
      line_prim_t                held;
      bit                        have_held;
      have_held = 1'b0;
      held      = '0;
      case (r.act)
        ACT_CLEAR: begin
          n_boxes = 0;
          return 1'b1;
        end
        ACT_APPEND: begin
          if (n_boxes == MAX_BOXES) return 1'b0;
          boxes[n_boxes] = r.box;
          n_boxes++;
          return 1'b1;
        end
        ACT_FILL: begin
          tx = r.rx + org_x;
          ty = r.ry + org_y;
          x0 = int'(tx);
          y0 = int'(ty);
          x1 = x0 + int'(r.rw);
          y1 = y0 + int'(r.rh);
          for (int i = 0; i < int'(n_boxes); i++) begin
            cx0 = (x0 > int'(boxes[i].left))   ? x0 : int'(boxes[i].left);
            cy0 = (y0 > int'(boxes[i].top))    ? y0 : int'(boxes[i].top);
            cx1 = (x1 < int'(boxes[i].right))  ? x1 : int'(boxes[i].right);
            cy1 = (y1 < int'(boxes[i].bottom)) ? y1 : int'(boxes[i].bottom);
            if (cx0 < cx1 && cy0 < cy1) begin
              if (have_held) pending.push_back(held);
              lw  = WORD_W'(((cy1 - cy0) << SHIFT_H) - 1);
              psy = WORD_W'(cy0 << SHIFT_Y) + lw;
              held.start_word = (WORD_W'(cx0) << SHIFT_X) | psy;
              held.end_word   = (WORD_W'(cx1) << SHIFT_X) | psy;
              held.width_code = CODE_W'(lw);
              held.last       = 1'b0;
              have_held       = 1'b1;
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            pending.push_back(held);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void cmp_field(string fname, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, seen);
        errors++;
      end
    endfunction

    function void check_prim(line_prim_t got);
      line_prim_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h %h %b", $time,
                 got.start_word, got.end_word, got.width_code, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("start_word", want.start_word, got.start_word);
      cmp_field("end_word", want.end_word, got.end_word);
      cmp_field("width_code", WORD_W'(want.width_code), WORD_W'(got.width_code));
      cmp_field("last", WORD_W'(want.last), WORD_W'(got.last));
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [1:0]                action_i;
  logic [EDGE_W-1:0]         box_left_i;
  logic [EDGE_W-1:0]         box_top_i;
  logic [EDGE_W-1:0]         box_right_i;
  logic [EDGE_W-1:0]         box_bottom_i;
  logic signed [COORD_W-1:0] rect_x_i;
  logic signed [COORD_W-1:0] rect_y_i;
  logic [COORD_W-1:0]        rect_width_i;
  logic [COORD_W-1:0]        rect_height_i;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [COORD_W-1:0]        cfg_wdata_i;
  logic                      valid_o;
  logic [WORD_W-1:0]         start_word_o;
  logic [WORD_W-1:0]         end_word_o;
  logic [CODE_W-1:0]         width_code_o;
  logic                      last_o;

  line_prim_t                seen_prim;
  clip_tracker               trk;
  int unsigned               items_sent = 0;
  int unsigned               cycle_count = 0;
  bit                        burst_mode = 1'b0;

  rect_clip_to_box_list dut (.*);

  assign seen_prim = {start_word_o, end_word_o, width_code_o, last_o};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) trk.check_prim(seen_prim);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic draw_req_t rand_req();
    draw_req_t r;
    r.act        = 2'($urandom);
    r.box.left   = EDGE_W'($urandom);
    r.box.top    = EDGE_W'($urandom);
    r.box.right  = EDGE_W'($urandom);
    r.box.bottom = EDGE_W'($urandom);
    r.rx         = COORD_W'($urandom);
    r.ry         = COORD_W'($urandom);
    r.rw         = COORD_W'($urandom);
    r.rh         = COORD_W'($urandom);
    return r;
  endfunction

  function automatic draw_req_t mk_plain(logic [1:0] act);
    draw_req_t r;
    r     = rand_req();
    r.act = act;
    return r;
  endfunction

  function automatic draw_req_t mk_append(int l, int t, int rt, int b);
    draw_req_t r;
    r            = mk_plain(ACT_APPEND);
    r.box.left   = EDGE_W'(l);
    r.box.top    = EDGE_W'(t);
    r.box.right  = EDGE_W'(rt);
    r.box.bottom = EDGE_W'(b);
    return r;
  endfunction

  function automatic draw_req_t mk_fill(int x, int y, int w, int h);
    draw_req_t r;
    r    = mk_plain(ACT_FILL);
    r.rx = COORD_W'(x);
    r.ry = COORD_W'(y);
    r.rw = COORD_W'(w);
    r.rh = COORD_W'(h);
    return r;
  endfunction

  // An edge pair near base, now and then empty or inverted.
  function automatic void pick_span(int base, output int lo, output int hi);
    lo = base + int'($urandom_range(0, 500));
    hi = lo + int'($urandom_range(1, 400));
    if (hi > EDGE_MAX) hi = EDGE_MAX;
    if ($urandom_range(0, 7) == 0) hi = int'($urandom_range(0, lo));
  endfunction

  task automatic send_req(draw_req_t r);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= r.act;
    box_left_i    <= r.box.left;
    box_top_i     <= r.box.top;
    box_right_i   <= r.box.right;
    box_bottom_i  <= r.box.bottom;
    rect_x_i      <= r.rx;
    rect_y_i      <= r.ry;
    rect_width_i  <= r.rw;
    rect_height_i <= r.rh;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (trk.note_request(r)) items_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (trk.pending.size() != 0) @(posedge clk_i);
  endtask

  // Fills that hit no box give no result, so let the back end settle as well.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_origins(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ORIGIN_X;
    cfg_wdata_i <= ox;
    @(posedge clk_i);
    trk.set_origin(CFG_ORIGIN_X, ox);
    cfg_idx_i   <= CFG_ORIGIN_Y;
    cfg_wdata_i <= oy;
    @(posedge clk_i);
    trk.set_origin(CFG_ORIGIN_Y, oy);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_box_sequence();
    int unsigned n_app;
    int unsigned n_fill;
    int          base_x, base_y, l, t, rt, b, tx, ty, w, h;
    burst_mode = ($urandom_range(0, 3) == 0);
    base_x     = int'($urandom_range(0, 7500));
    base_y     = int'($urandom_range(0, 7500));
    n_app      = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
    if ($urandom_range(0, 4) != 0) send_req(mk_plain(ACT_CLEAR));
    repeat (n_app) begin
      pick_span(base_x, l, rt);
      pick_span(base_y, t, b);
      send_req(mk_append(l, t, rt, b));
    end
    n_fill = $urandom_range(1, 4);
    repeat (n_fill) begin
      tx = base_x - 200 + int'($urandom_range(0, 1100));
      ty = base_y - 200 + int'($urandom_range(0, 1100));
      w  = ($urandom_range(0, 9) == 0) ? 65535 : int'($urandom_range(0, 900));
      h  = ($urandom_range(0, 9) == 0) ? 65535 : int'($urandom_range(0, 900));
      send_req(mk_fill(tx - int'(trk.org_x), ty - int'(trk.org_y), w, h));
    end
  endtask

  initial begin
    logic [COORD_W-1:0] ox, oy;
    int unsigned        phase_end;
    trk           = new();
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    action_i      <= ACT_CLEAR;
    box_left_i    <= '0;
    box_top_i     <= '0;
    box_right_i   <= '0;
    box_bottom_i  <= '0;
    rect_x_i      <= '0;
    rect_y_i      <= '0;
    rect_width_i  <= '0;
    rect_height_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ORIGIN_X;
    cfg_wdata_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk_fill(0, 0, 100, 100));
    send_req(mk_plain(ACT_UNUSED));
    send_req(mk_append(0, 0, EDGE_MAX, EDGE_MAX));
    send_req(mk_append(100, 0, 100, 50));
    send_req(mk_append(0, 200, 50, 100));
    send_req(mk_append(10, 20, 30, 40));
    send_req(mk_fill(0, 0, 65535, 65535));
    send_req(mk_fill(-32768, -32768, 65535, 65535));
    send_req(mk_fill(25, 35, 0, 10));
    send_req(mk_fill(25, 35, 10, 0));
    send_req(mk_fill(32767, 32767, 65535, 65535));
    send_req(mk_fill(8190, 8190, 1, 1));
    send_req(mk_fill(-5, -5, 20, 30));
    send_req(mk_plain(ACT_CLEAR));
    send_req(mk_fill(0, 0, 100, 100));
    send_req(mk_append(5, 5, 6, 6));
    send_req(mk_fill(0, 0, 10, 10));
    send_req(mk_append(0, 0, 0, 0));
    set_origins(16'h7fff, 16'h8000);
    send_req(mk_fill(32767, -32768, 10, 10));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin ox = 16'h0000; oy = 16'h0000; end
        1:       begin ox = 16'h7fff; oy = 16'h8000; end
        2:       begin ox = 16'h8000; oy = 16'h7fff; end
        3:       begin ox = 16'hffff; oy = 16'hffff; end
        default: begin ox = COORD_W'($urandom); oy = COORD_W'($urandom); end
      endcase
      set_origins(ox, oy);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          run_box_sequence();
        end else begin
          burst_mode = 1'b0;
          send_req(rand_req());
        end
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    wait_idle();
    if (trk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rcb_pkg.sv
rtl/rcb_front.sv
rtl/rcb_queue.sv
rtl/rcb_back.sv
rtl/rect_clip_to_box_list.sv
sim/tb_rect_clip_to_box_list.sv
